>>> rtl/rwcp_pkg.sv
// Package for the register write command parser: field widths, character
// codes, parser state type, result struct and the hex digit decoder.
// No dependencies.
`default_nettype none

package rwcp_pkg;

  // Field widths.
  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned REG_NUM_W   = 4;
  localparam int unsigned REG_ADDR_W  = 8;
  localparam int unsigned DEV_ADDR_W  = 7;
  localparam int unsigned VALUE_W     = 8;
  localparam int unsigned CFG_IDX_W   = 8;
  localparam int unsigned CFG_DATA_W  = 8;

  // Default number of control registers.
  localparam int unsigned NUM_CONTROL_REGS_DEF = 9;

  // Character codes.
  localparam logic [CHAR_W-1:0] CH_C_UPPER = 8'h43;
  localparam logic [CHAR_W-1:0] CH_C_LOWER = 8'h63;
  localparam logic [CHAR_W-1:0] CH_EQUALS  = 8'h3D;
  localparam logic [CHAR_W-1:0] CH_CR      = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_ONE     = 8'h31;
  localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
  localparam logic [CHAR_W-1:0] CH_A_UPPER = 8'h41;
  localparam logic [CHAR_W-1:0] CH_F_UPPER = 8'h46;
  localparam logic [CHAR_W-1:0] CH_A_LOWER = 8'h61;
  localparam logic [CHAR_W-1:0] CH_F_LOWER = 8'h66;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDR = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEV_ADDR  = 8'd1;

  // Parser states.
  typedef enum logic [2:0] {
    PS_IDLE   = 3'd0,
    PS_LETTER = 3'd1,
    PS_DIGIT  = 3'd2,
    PS_EQUALS = 3'd3,
    PS_HEX1   = 3'd4,
    PS_HEX2   = 3'd5
  } parse_state_t;

  // One bus write.
  typedef struct packed {
    logic [REG_NUM_W-1:0]  register_number;
    logic [REG_ADDR_W-1:0] register_address;
    logic [DEV_ADDR_W-1:0] device_address;
    logic [VALUE_W-1:0]    write_value;
  } result_t;

  // Decoded hex digit.
  typedef struct packed {
    logic       ok;
    logic [3:0] nib;
  } hex_t;

  // Decode 0-9, A-F and a-f into a nibble.
  function automatic hex_t hex_decode(input logic [CHAR_W-1:0] ch);
    hex_t h;
    h.ok  = 1'b0;
    h.nib = 4'd0;
    if (ch >= CH_ZERO && ch <= CH_NINE) begin
      h.ok  = 1'b1;
      h.nib = ch[3:0];
    end else if ((ch >= CH_A_UPPER && ch <= CH_F_UPPER) ||
                 (ch >= CH_A_LOWER && ch <= CH_F_LOWER)) begin
      // Letters A..F have low bits 1..6; add 9 to get 10..15.
      h.ok  = 1'b1;
      h.nib = ch[3:0] + 4'd9;
    end
    return h;
  endfunction

endpackage

`default_nettype wire

>>> rtl/rwcp_if.sv
// Handshake interfaces for the received character channel, the write
// result channel and the configuration write channel. Uses rwcp_pkg.
`default_nettype none

interface rwcp_rx_if;
  logic                         valid;
  logic                         ready;
  logic [rwcp_pkg::CHAR_W-1:0]  rx_char;
  modport source (output valid, output rx_char, input ready);
  modport sink   (input valid, input rx_char, output ready);
endinterface

interface rwcp_wr_if;
  logic                             valid;
  logic                             ready;
  logic [rwcp_pkg::REG_NUM_W-1:0]   register_number;
  logic [rwcp_pkg::REG_ADDR_W-1:0]  register_address;
  logic [rwcp_pkg::DEV_ADDR_W-1:0]  device_address;
  logic [rwcp_pkg::VALUE_W-1:0]     write_value;
  modport source (output valid, output register_number, output register_address,
                  output device_address, output write_value, input ready);
  modport sink   (input valid, input register_number, input register_address,
                  input device_address, input write_value, output ready);
endinterface

interface rwcp_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [rwcp_pkg::CFG_IDX_W-1:0]   index;
  logic [rwcp_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/rwcp_parser.sv
// Character parser: state machine plus held register number and value.
// Produces one write result on the carriage return that ends a command.
// Uses rwcp_pkg.
`default_nettype none

module rwcp_parser #(
  parameter int unsigned NUM_CONTROL_REGS = rwcp_pkg::NUM_CONTROL_REGS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               accept,
  input  wire logic [rwcp_pkg::CHAR_W-1:0]        rx_char,
  input  wire logic [rwcp_pkg::REG_ADDR_W-1:0]    base_addr,
  input  wire logic [rwcp_pkg::DEV_ADDR_W-1:0]    dev_addr,
  output logic                                    issue,
  output rwcp_pkg::result_t                       result
);

  localparam logic [rwcp_pkg::CHAR_W-1:0] LastDigit =
    rwcp_pkg::CH_ZERO + rwcp_pkg::CHAR_W'(NUM_CONTROL_REGS);

  rwcp_pkg::parse_state_t state, state_next;
  logic [rwcp_pkg::REG_NUM_W-1:0] held_num;
  logic [rwcp_pkg::VALUE_W-1:0]   held_value;

  rwcp_pkg::hex_t hex;
  logic is_letter, is_digit;
  logic load_num, load_hi, load_lo;

  assign hex       = rwcp_pkg::hex_decode(rx_char);
  assign is_letter = (rx_char == rwcp_pkg::CH_C_UPPER) || (rx_char == rwcp_pkg::CH_C_LOWER);
  assign is_digit  = (rx_char >= rwcp_pkg::CH_ONE) && (rx_char <= LastDigit);

  // Next state: any unexpected character goes back to idle.
  always_comb begin
    state_next = rwcp_pkg::PS_IDLE;
    unique case (state)
      rwcp_pkg::PS_IDLE:   if (is_letter) state_next = rwcp_pkg::PS_LETTER;
      rwcp_pkg::PS_LETTER: if (is_digit) state_next = rwcp_pkg::PS_DIGIT;
      rwcp_pkg::PS_DIGIT:  if (rx_char == rwcp_pkg::CH_EQUALS) state_next = rwcp_pkg::PS_EQUALS;
      rwcp_pkg::PS_EQUALS: if (hex.ok) state_next = rwcp_pkg::PS_HEX1;
      rwcp_pkg::PS_HEX1:   if (hex.ok) state_next = rwcp_pkg::PS_HEX2;
      default:             state_next = rwcp_pkg::PS_IDLE;
    endcase
  end

  // Outputs of the state machine.
  always_comb begin
    load_num = 1'b0;
    load_hi  = 1'b0;
    load_lo  = 1'b0;
    issue    = 1'b0;
    unique case (state)
      rwcp_pkg::PS_LETTER: load_num = accept && is_digit;
      rwcp_pkg::PS_EQUALS: load_hi  = accept && hex.ok;
      rwcp_pkg::PS_HEX1:   load_lo  = accept && hex.ok;
      rwcp_pkg::PS_HEX2:   issue    = accept && (rx_char == rwcp_pkg::CH_CR) &&
                                      (held_num != '0) &&
                                      (held_num <= rwcp_pkg::REG_NUM_W'(NUM_CONTROL_REGS));
      default: ;
    endcase
  end

  // State and held fields.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= rwcp_pkg::PS_IDLE;
      held_num   <= '0;
      held_value <= '0;
    end else if (accept) begin
      state <= state_next;
      if (load_num) held_num <= rx_char[3:0];
      if (load_hi)  held_value <= {hex.nib, 4'd0};
      if (load_lo)  held_value <= {held_value[7:4], hex.nib};
    end
  end

  // Result fields; address wraps at eight bits.
  always_comb begin
    result.register_number  = held_num;
    result.register_address = base_addr + rwcp_pkg::REG_ADDR_W'(held_num) - 8'd1;
    result.device_address   = dev_addr;
    result.write_value      = held_value;
  end

endmodule

`default_nettype wire

>>> rtl/rwcp_out_reg.sv
// Output register for write results with valid/ready handshake.
// Uses rwcp_pkg and rwcp_wr_if.
`default_nettype none

module rwcp_out_reg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire rwcp_pkg::result_t result,
  output logic                   can_load,
  rwcp_wr_if.source              wr
);

  logic              valid;
  rwcp_pkg::result_t data;

  // A new result may enter when the register is empty or being drained.
  assign can_load = !valid || wr.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (wr.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) data <= result;
  end

  assign wr.valid            = valid;
  assign wr.register_number  = data.register_number;
  assign wr.register_address = data.register_address;
  assign wr.device_address   = data.device_address;
  assign wr.write_value      = data.write_value;

endmodule

`default_nettype wire

>>> rtl/register_write_command_parser.sv
// Register write command parser.
// Each item on rx is one received character. Commands have the form
// C or c, a register digit 1..NUM_CONTROL_REGS, '=', two hex digits and a
// carriage return. The carriage return that completes a command yields one
// item on wr: register number, bus register address (base + n - 1, mod 256),
// device address and the byte value. Any unexpected character returns the
// parser to idle without a result.
// Configuration: cfg writes index 0 (control base address) and index 1
// (target device address); cfg is always ready. Write only while idle.
// Throughput: one character per cycle while rx.ready is high. A result appears on wr in
// the cycle after the carriage return is accepted, held in a single output register.
// When the receiver stalls wr, rx.ready drops only while a result waits
// and the receiver is not taking it; rx.ready does not depend on parser state.
// Reset (rst, synchronous) puts the parser in idle, clears held fields,
// configuration and the shadow copy of the control registers, and empties
// the output register.
// Depends on rwcp_pkg, rwcp_if, rwcp_parser and rwcp_out_reg.
`default_nettype none

module register_write_command_parser #(
  parameter int unsigned NUM_CONTROL_REGS = rwcp_pkg::NUM_CONTROL_REGS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  rwcp_rx_if.sink    rx,
  rwcp_wr_if.source  wr,
  rwcp_cfg_if.sink   cfg
);

  localparam int unsigned IdxW = (NUM_CONTROL_REGS > 1) ? $clog2(NUM_CONTROL_REGS) : 1;

  logic [rwcp_pkg::REG_ADDR_W-1:0] base_addr;
  logic [rwcp_pkg::DEV_ADDR_W-1:0] dev_addr;
  logic [rwcp_pkg::VALUE_W-1:0]    shadow [NUM_CONTROL_REGS];

  logic              accept, issue, can_load;
  rwcp_pkg::result_t result;
  logic [IdxW-1:0]   shadow_idx;

  // Configuration registers.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_addr <= '0;
      dev_addr  <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        rwcp_pkg::CFG_BASE_ADDR: base_addr <= cfg.data;
        rwcp_pkg::CFG_DEV_ADDR:  dev_addr  <= cfg.data[rwcp_pkg::DEV_ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  // Input handshake.
  assign rx.ready = can_load;
  assign accept   = rx.valid && rx.ready;

  rwcp_parser #(
    .NUM_CONTROL_REGS(NUM_CONTROL_REGS)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .rx_char   (rx.rx_char),
    .base_addr (base_addr),
    .dev_addr  (dev_addr),
    .issue     (issue),
    .result    (result)
  );

  rwcp_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (issue),
    .result   (result),
    .can_load (can_load),
    .wr       (wr)
  );

  // Shadow copy of the control registers, updated on each write.
  assign shadow_idx = IdxW'(result.register_number - 4'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_CONTROL_REGS; k++) shadow[k] <= '0;
    end else if (issue) begin
      shadow[shadow_idx] <= result.write_value;
    end
  end

  // Checks.
  a_num_range: assert property (@(posedge clk) disable iff (rst)
    wr.valid |-> (wr.register_number != '0) &&
                 (wr.register_number <= rwcp_pkg::REG_NUM_W'(NUM_CONTROL_REGS)))
    else $error("write result register number out of range");

  a_addr_match: assert property (@(posedge clk) disable iff (rst)
    wr.valid |-> wr.register_address ==
                 base_addr + rwcp_pkg::REG_ADDR_W'(wr.register_number) - 8'd1)
    else $error("write result address does not match base and number");

  a_shadow_upd: assert property (@(posedge clk) disable iff (rst)
    issue |=> shadow[$past(shadow_idx)] == wr.write_value)
    else $error("shadow copy not updated with issued value");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    !rx.ready |-> wr.valid && !wr.ready)
    else $error("input stalled without a pending result");

endmodule

`default_nettype wire

>>> sim/register_write_command_parser_tb.sv
// Self-checking testbench for the register write command parser.
// Drives characters, checks every bus write against a behavioral parser.
// Depends on rwcp_pkg, rwcp_if and the register_write_command_parser RTL.
`timescale 1ns / 100ps

module register_write_command_parser_tb;
  import rwcp_pkg::*;

  localparam int unsigned NUM_REGS    = NUM_CONTROL_REGS_DEF;
  localparam int          STALL_LEN   = 300;
  localparam int          DRAIN_WAIT  = 6;
  localparam int          QUIET_LIMIT = 4000;

  // Clock, reset and the values the bench puts on the block's inputs.
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  char_valid = 1'b0;
  logic [CHAR_W-1:0]     char_data = '0;
  logic                  write_ready = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Traffic queues and run bookkeeping.
  logic [CHAR_W-1:0] pending_chars[$];
  result_t           expected_writes[$];
  int                sender_idle_pct = 0;
  int                receiver_idle_pct = 0;
  int                long_stall_requests = 0;
  int                long_stalls_served = 0;
  int                stall_left = 0;
  int                mismatch_count = 0;
  int                chars_accepted = 0;
  int                writes_checked = 0;
  int                settings_used = 0;
  int                quiet_cycles = 0;

  // Behavioral copy of the parser state and its configuration.
  parse_state_t          model_state = PS_IDLE;
  logic [REG_NUM_W-1:0]  model_reg_num = '0;
  logic [VALUE_W-1:0]    model_value = '0;
  logic [VALUE_W-1:0]    model_shadow [NUM_REGS];
  logic [REG_ADDR_W-1:0] model_base = '0;
  logic [DEV_ADDR_W-1:0] model_dev = '0;

  rwcp_rx_if  rx_bus ();
  rwcp_wr_if  wr_bus ();
  rwcp_cfg_if cfg_bus ();

  assign rx_bus.valid   = char_valid;
  assign rx_bus.rx_char = char_data;
  assign wr_bus.ready   = write_ready;
  assign cfg_bus.valid  = cfg_valid;
  assign cfg_bus.index  = cfg_index;
  assign cfg_bus.data   = cfg_data;

  register_write_command_parser u_top (
    .clk (clk),
    .rst (rst),
    .rx  (rx_bus),
    .wr  (wr_bus),
    .cfg (cfg_bus)
  );

  always #10 clk = ~clk;

  // Hex digit value as {valid, nibble}.
  function automatic logic [4:0] hex_value(input logic [CHAR_W-1:0] ch);
    if (ch >= CH_ZERO && ch <= CH_NINE) begin
      return {1'b1, 4'(ch - CH_ZERO)};
    end else if (ch >= CH_A_UPPER && ch <= CH_F_UPPER) begin
      return {1'b1, 4'(ch - CH_A_UPPER + 10)};
    end else if (ch >= CH_A_LOWER && ch <= CH_F_LOWER) begin
      return {1'b1, 4'(ch - CH_A_LOWER + 10)};
    end
    return 5'd0;
  endfunction

  // Character for a nibble, letters in either case.
  function automatic logic [CHAR_W-1:0] hex_char(input int nib, input bit lower);
    if (nib < 10) begin
      return CH_ZERO + 8'(nib);
    end
    return (lower ? CH_A_LOWER : CH_A_UPPER) + 8'(nib - 10);
  endfunction

  // Advance the parser by one character and queue the write it completes.
  task automatic parse_expected(input logic [CHAR_W-1:0] ch);
    parse_state_t nxt;
    logic [4:0]   hex;
    result_t      wr_item;
    nxt = PS_IDLE;
    hex = hex_value(ch);
    case (model_state)
      PS_LETTER: begin
        if (ch >= CH_ONE && ch <= CH_ZERO + NUM_REGS) begin
          model_reg_num = ch[3:0];
          nxt = PS_DIGIT;
        end
      end
      PS_DIGIT: begin
        if (ch == CH_EQUALS) nxt = PS_EQUALS;
      end
      PS_EQUALS: begin
        if (hex[4]) begin
          model_value = {hex[3:0], 4'h0};
          nxt = PS_HEX1;
        end
      end
      PS_HEX1: begin
        if (hex[4]) begin
          model_value = model_value | {4'h0, hex[3:0]};
          nxt = PS_HEX2;
        end
      end
      PS_HEX2: begin
        if (ch == CH_CR && model_reg_num >= 1 && model_reg_num <= NUM_REGS) begin
          model_shadow[model_reg_num - 1] = model_value;
          wr_item.register_number  = model_reg_num;
          wr_item.register_address = model_base + {4'd0, model_reg_num} - 8'd1;
          wr_item.device_address   = model_dev;
          wr_item.write_value      = model_value;
          expected_writes.push_back(wr_item);
        end
      end
      default: begin
        // Idle, and any unused code behaves as idle.
        if (ch == CH_C_UPPER || ch == CH_C_LOWER) nxt = PS_LETTER;
      end
    endcase
    model_state = nxt;
  endtask

  // Character driver: holds an item until it is taken, idles at random.
  always @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
    end else begin
      if (char_valid && rx_bus.ready) begin
        parse_expected(char_data);
        chars_accepted++;
      end
      if (!char_valid || rx_bus.ready) begin
        if (pending_chars.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          char_data  <= pending_chars.pop_front();
          char_valid <= 1'b1;
        end else begin
          char_valid <= 1'b0;
        end
      end
    end
  end

  // Write monitor: checks each taken write, drives ready with stalls.
  always @(posedge clk) begin
    if (rst) begin
      write_ready <= 1'b0;
    end else begin
      if (wr_bus.valid && write_ready) begin
        if (expected_writes.size() == 0) begin
          $display("%0t: unexpected write num=%0d addr=%02h dev=%02h val=%02h", $time,
                   wr_bus.register_number, wr_bus.register_address,
                   wr_bus.device_address, wr_bus.write_value);
          mismatch_count++;
        end else begin
          if (wr_bus.register_number !== expected_writes[0].register_number ||
              wr_bus.register_address !== expected_writes[0].register_address ||
              wr_bus.device_address !== expected_writes[0].device_address ||
              wr_bus.write_value !== expected_writes[0].write_value) begin
            $display("%0t: write mismatch expected num=%0d addr=%02h dev=%02h val=%02h",
                     $time, expected_writes[0].register_number,
                     expected_writes[0].register_address,
                     expected_writes[0].device_address, expected_writes[0].write_value);
            $display("%0t:                  actual num=%0d addr=%02h dev=%02h val=%02h",
                     $time, wr_bus.register_number, wr_bus.register_address,
                     wr_bus.device_address, wr_bus.write_value);
            mismatch_count++;
          end
          void'(expected_writes.pop_front());
          writes_checked++;
        end
      end
      // A requested long hold-off takes priority over random idling.
      if (stall_left > 0) begin
        stall_left  <= stall_left - 1;
        write_ready <= 1'b0;
      end else if (long_stalls_served < long_stall_requests) begin
        long_stalls_served <= long_stalls_served + 1;
        stall_left  <= STALL_LEN;
        write_ready <= 1'b0;
      end else begin
        write_ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
    end
  end

  // Watchdog on cycles in which no channel moves an item.
  always @(posedge clk) begin
    if (!rst) begin
      if ((char_valid && rx_bus.ready) || (wr_bus.valid && write_ready) ||
          (cfg_valid && cfg_bus.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Write both configuration registers back to back; call at a clock edge.
  task automatic write_config(input logic [7:0] base, input logic [7:0] dev);
    cfg_index <= CFG_BASE_ADDR;
    cfg_data  <= base;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_bus.ready);
    model_base = base;
    cfg_index <= CFG_DEV_ADDR;
    cfg_data  <= dev;
    do @(posedge clk); while (!cfg_bus.ready);
    model_dev = dev[DEV_ADDR_W-1:0];
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) pending_chars.push_back(s[i]);
  endtask

  // Mostly well-formed commands with random content, some broken ones and noise.
  task automatic queue_traffic(input int count);
    int                added;
    int                pick;
    int                len;
    int                cut;
    logic [CHAR_W-1:0] cmd [6];
    added = 0;
    while (added < count) begin
      pick   = $urandom_range(99);
      cmd[0] = $urandom_range(1) ? CH_C_UPPER : CH_C_LOWER;
      cmd[1] = CH_ZERO + 8'($urandom_range(NUM_REGS, 1));
      cmd[2] = CH_EQUALS;
      cmd[3] = hex_char($urandom_range(15), $urandom_range(1));
      cmd[4] = hex_char($urandom_range(15), $urandom_range(1));
      cmd[5] = CH_CR;
      if (pick < 15) begin
        pending_chars.push_back(8'($urandom_range(255)));
        added++;
      end else begin
        len = 6;
        if (pick < 30) begin
          cut      = $urandom_range(5);
          cmd[cut] = 8'($urandom_range(255));
          len      = cut + 1;
        end
        for (int i = 0; i < len; i++) pending_chars.push_back(cmd[i]);
        added += len;
      end
    end
  endtask

  // Let the driver empty, wait for every write, then allow the pipeline to settle.
  task automatic drain;
    do @(posedge clk); while (pending_chars.size() != 0 || char_valid);
    while (expected_writes.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Test sequence.
  initial begin
    for (int i = 0; i < NUM_REGS; i++) model_shadow[i] = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: extreme registers and bytes, address wrap, the abort cases of a
    // repeated letter, digit zero and a digit past the last register, then C
    // letters accepted as hex value digits.
    write_config(8'hFF, 8'h7F);
    push_text("C1=00");
    pending_chars.push_back(CH_CR);
    push_text("c9=fF");
    pending_chars.push_back(CH_CR);
    push_text("CCC0C:");
    push_text("C5=Cc");
    pending_chars.push_back(CH_CR);
    drain();

    // Sender rarely idles, receiver mostly stalls, one long hold-off.
    write_config(8'h00, 8'h00);
    sender_idle_pct   = 7;
    receiver_idle_pct = 75;
    long_stall_requests++;
    queue_traffic(380);
    drain();

    // Roles swapped.
    write_config(8'($urandom_range(255)), 8'($urandom_range(255)));
    sender_idle_pct   = 75;
    receiver_idle_pct = 7;
    queue_traffic(380);
    drain();

    // Full rate on both sides, with another long hold-off.
    write_config(8'($urandom_range(255)), 8'($urandom_range(255)));
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    long_stall_requests++;
    queue_traffic(390);
    drain();

    $display("Checked %0d writes from %0d characters under %0d configurations,",
             writes_checked, chars_accepted, settings_used);
    $display("with idling on both sides and %0d long receiver hold-offs.",
             long_stalls_served);
    if (mismatch_count == 0 && expected_writes.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
